@@ hw/rtl/m4inv_pkg.sv @@
package m4inv_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SHIFT     = 2 * FRAC_BITS;
	localparam int E_W       = 32;
	// Accumulator: the determinant stays below 24 * 2^124 in magnitude.
	localparam int ACC_W     = 132;
	// Magnitude register: cofactors stay below 6 * 2^93.
	localparam int A_W       = 96;
	localparam int ADJ_W     = A_W + 1;
	localparam int N_W       = A_W + SHIFT;
	localparam int REM_W     = (ACC_W + 1 > N_W - E_W) ? ACC_W + 1 : N_W - E_W;
	localparam int DIV_STEPS = E_W;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_MUL_EE,
		OP_MUL_AE,
		OP_LDA_M,
		OP_LDA_ADJ,
		OP_STORE,
		OP_DLOAD,
		OP_CLOAD,
		OP_DCMP,
		OP_DSTEP,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		TGT_M,
		TGT_C,
		TGT_D
	} tgt_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] addr_a;
		logic [3:0] addr_b;
		logic [1:0] chunk;
		logic       sub;
		logic       first;
		tgt_t       tgt;
		logic       last;
		logic       wr_en;
		logic [3:0] wr_addr;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} sts_t;

	// n-th index of 0..3 that skips k (n in 0..2).
	function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] n);
		logic [1:0] r;
		r = (n < k) ? n : n + 2'd1;
		return r;
	endfunction

endpackage

@@ hw/rtl/m4inv_dp.sv @@
module m4inv_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  m4inv_pkg::cmd_t         cmd,
	input  logic signed [31:0]      elem_value,
	output m4inv_pkg::sts_t         sts,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [31:0]      result_value,
	output logic                    result_last,
	output logic                    singular,
	output logic                    saturated
);
	import m4inv_pkg::*;

	logic [E_W-1:0]   elem_mem [16];
	logic [ADJ_W-1:0] adj_mem  [16];

	// stage 1: operand read
	logic [E_W-1:0] rd_a_s1, rd_b_s1;
	logic           vld_s1, ee_s1, sub_s1, first_s1;
	logic [1:0]     chunk_s1;
	tgt_t           tgt_s1;

	// stage 2: product
	logic [2*E_W-1:0] prod_s2;
	logic             vld_s2, neg_s2, first_s2;
	logic [1:0]       chunk_s2;
	tgt_t             tgt_s2;

	logic [ACC_W-1:0] macc_q, cacc_q, dacc_q;
	logic [A_W-1:0]   a_mag_q;
	logic             a_neg_q;
	logic [ADJ_W-1:0] adj_rd_q;

	logic [ACC_W-1:0] dmag_q;
	logic             dneg_q, sing_q;
	logic [REM_W-1:0] rem_q;
	logic [E_W-1:0]   nlow_q, q_q;
	logic [A_W-1:0]   sq_q;
	logic             cneg_q, big_q;

	logic             out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			elem_mem[cmd.wr_addr] <= elem_value;
		end
		rd_a_s1 <= elem_mem[cmd.addr_a];
		rd_b_s1 <= elem_mem[cmd.addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (cmd.op == OP_MUL_EE) || (cmd.op == OP_MUL_AE);
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ee_s1    <= (cmd.op == OP_MUL_EE);
		sub_s1   <= cmd.sub;
		first_s1 <= cmd.first;
		chunk_s1 <= cmd.chunk;
		tgt_s1   <= cmd.tgt;
	end

	logic [E_W-1:0] mag_a, mag_b, opa;
	always_comb begin
		mag_a = rd_a_s1[E_W-1] ? (~rd_a_s1 + 1'b1) : rd_a_s1;
		mag_b = rd_b_s1[E_W-1] ? (~rd_b_s1 + 1'b1) : rd_b_s1;
		opa   = ee_s1 ? mag_a : a_mag_q[chunk_s1*E_W +: E_W];
	end

	always_ff @(posedge clk) begin
		prod_s2  <= opa * mag_b;
		neg_s2   <= (ee_s1 ? rd_a_s1[E_W-1] : a_neg_q) ^ rd_b_s1[E_W-1] ^ sub_s1;
		first_s2 <= first_s1;
		chunk_s2 <= chunk_s1;
		tgt_s2   <= tgt_s1;
	end

	// stage 3: accumulate into the selected accumulator
	logic [ACC_W-1:0] term, base, acc_nx;
	always_comb begin
		term = ACC_W'(prod_s2) << (E_W * chunk_s2);
		case (tgt_s2)
			TGT_M:   base = macc_q;
			TGT_C:   base = cacc_q;
			TGT_D:   base = dacc_q;
			default: base = macc_q;
		endcase
		if (first_s2) base = '0;
		acc_nx = base + (neg_s2 ? ~term : term) + ACC_W'(neg_s2);
	end

	logic [A_W-1:0]   adj_mag;
	logic [ACC_W-1:0] macc_mag;
	logic [N_W-1:0]   num;
	logic [REM_W-1:0] dmag_w, rem2;
	logic             ge;
	always_comb begin
		adj_mag  = A_W'(adj_rd_q[ADJ_W-1] ? (~adj_rd_q + 1'b1) : adj_rd_q);
		macc_mag = macc_q[ACC_W-1] ? (~macc_q + 1'b1) : macc_q;
		num      = {adj_mag, SHIFT'(0)};
		dmag_w   = REM_W'(dmag_q);
		rem2     = {rem_q[REM_W-2:0], nlow_q[E_W-1]};
		ge       = rem2 >= dmag_w;
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			case (tgt_s2)
				TGT_M:   macc_q <= acc_nx;
				TGT_C:   cacc_q <= acc_nx;
				TGT_D:   dacc_q <= acc_nx;
				default: macc_q <= acc_nx;
			endcase
		end
		// registered cofactor read: the address is presented in the cycle before its use
		adj_rd_q <= adj_mem[cmd.addr_a];
		case (cmd.op)
			OP_LDA_M: begin
				a_mag_q <= macc_mag[A_W-1:0];
				a_neg_q <= macc_q[ACC_W-1];
			end
			OP_LDA_ADJ: begin
				a_mag_q <= adj_mag;
				a_neg_q <= adj_rd_q[ADJ_W-1];
			end
			OP_STORE: begin
				adj_mem[cmd.addr_a] <= cacc_q[ADJ_W-1:0];
			end
			OP_DLOAD: begin
				dmag_q <= dacc_q[ACC_W-1] ? (~dacc_q + 1'b1) : dacc_q;
				dneg_q <= dacc_q[ACC_W-1];
				sing_q <= (dacc_q == '0);
			end
			OP_CLOAD: begin
				rem_q  <= REM_W'(num[N_W-1:E_W]);
				nlow_q <= num[E_W-1:0];
				sq_q   <= adj_mag >> SHIFT;
				cneg_q <= adj_rd_q[ADJ_W-1];
				q_q    <= '0;
			end
			OP_DCMP: begin
				big_q <= rem_q >= dmag_w;
			end
			OP_DSTEP: begin
				rem_q  <= ge ? (rem2 - dmag_w) : rem2;
				nlow_q <= {nlow_q[E_W-2:0], 1'b0};
				q_q    <= {q_q[E_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	// saturate the quotient (or the scaled-down cofactor) to 32 bits
	logic           r_neg, r_hi, r_sat;
	logic [E_W-1:0] r_lo, r_val;
	always_comb begin
		r_neg = sing_q ? cneg_q : (cneg_q ^ dneg_q);
		r_hi  = sing_q ? (|sq_q[A_W-1:E_W]) : big_q;
		r_lo  = sing_q ? sq_q[E_W-1:0] : q_q;
		if (!r_neg) begin
			r_sat = r_hi || (r_lo > 32'h7FFF_FFFF);
			r_val = r_sat ? 32'h7FFF_FFFF : r_lo;
		end else begin
			r_sat = r_hi || (r_lo > 32'h8000_0000);
			r_val = r_sat ? 32'h8000_0000 : (~r_lo + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			result_value <= r_val;
			result_last  <= cmd.last;
			singular     <= sing_q;
			saturated    <= r_sat;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.pipe_busy = vld_s1 || vld_s2;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

@@ hw/rtl/m4inv_ctrl.sv @@
module m4inv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  m4inv_pkg::sts_t sts,
	output m4inv_pkg::cmd_t cmd
);
	import m4inv_pkg::*;

	typedef enum logic [14:0] {
		ST_LOAD  = 15'b000000000000001,
		ST_MINOR = 15'b000000000000010,
		ST_WAITM = 15'b000000000000100,
		ST_COF   = 15'b000000000001000,
		ST_WAITC = 15'b000000000010000,
		ST_DLDA  = 15'b000000000100000,
		ST_DADJ  = 15'b000000001000000,
		ST_DET   = 15'b000000010000000,
		ST_DWAIT = 15'b000000100000000,
		ST_CRD   = 15'b000001000000000,
		ST_CLD   = 15'b000010000000000,
		ST_DCMP  = 15'b000100000000000,
		ST_DIV   = 15'b001000000000000,
		ST_EMIT  = 15'b010000000000000,
		ST_IDLE  = 15'b100000000000000
	} state_t;

	state_t     state_q, state_nx;
	logic [3:0] cnt_q, cnt_nx;
	logic [1:0] term_q, term_nx;
	logic [1:0] sub_q, sub_nx;
	logic [4:0] div_q, div_nx;

	logic [1:0] ci, rk, r0, r1, r2, c0, c1, c2, ca, cb, cj;
	always_comb begin
		ci = cnt_q[3:2];
		rk = cnt_q[1:0];
		r0 = skip_idx(rk, 2'd0);
		r1 = skip_idx(rk, 2'd1);
		r2 = skip_idx(rk, 2'd2);
		c0 = skip_idx(ci, 2'd0);
		c1 = skip_idx(ci, 2'd1);
		c2 = skip_idx(ci, 2'd2);
		ca = (term_q == 2'd0) ? c1 : c0;
		cb = (term_q == 2'd2) ? c1 : c2;
		case (term_q)
			2'd0:    cj = c0;
			2'd1:    cj = c1;
			default: cj = c2;
		endcase
	end

	always_comb begin
		state_nx    = state_q;
		cnt_nx      = cnt_q;
		term_nx     = term_q;
		sub_nx      = sub_q;
		div_nx      = div_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.op      = OP_NOP;
		cmd.tgt     = TGT_M;
		cmd.wr_addr = cnt_q;
		case (state_q)
			ST_LOAD: begin
				in_ready   = 1'b1;
				cmd.wr_en  = in_valid;
				if (in_valid) begin
					cnt_nx = cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						term_nx  = '0;
						sub_nx   = '0;
						state_nx = ST_MINOR;
					end
				end
			end
			ST_MINOR: begin
				// two products of the 2x2 minor in rows r1, r2
				cmd.op    = OP_MUL_EE;
				cmd.tgt   = TGT_M;
				cmd.first = (sub_q == 2'd0);
				cmd.sub   = (sub_q != 2'd0);
				cmd.addr_a = (sub_q == 2'd0) ? {r1, ca} : {r1, cb};
				cmd.addr_b = (sub_q == 2'd0) ? {r2, cb} : {r2, ca};
				sub_nx    = sub_q + 2'd1;
				if (sub_q != 2'd0) begin
					sub_nx   = '0;
					state_nx = ST_WAITM;
				end
			end
			ST_WAITM: begin
				if (!sts.pipe_busy) begin
					cmd.op   = OP_LDA_M;
					state_nx = ST_COF;
				end
			end
			ST_COF: begin
				cmd.op     = OP_MUL_AE;
				cmd.tgt    = TGT_C;
				cmd.chunk  = sub_q;
				cmd.addr_b = {r0, cj};
				cmd.sub    = (term_q == 2'd1) ^ ci[0] ^ rk[0];
				cmd.first  = (term_q == 2'd0) && (sub_q == 2'd0);
				sub_nx     = sub_q + 2'd1;
				if (sub_q == 2'd1) begin
					sub_nx = '0;
					if (term_q == 2'd2) begin
						state_nx = ST_WAITC;
					end else begin
						term_nx  = term_q + 2'd1;
						state_nx = ST_MINOR;
					end
				end
			end
			ST_WAITC: begin
				if (!sts.pipe_busy) begin
					cmd.op     = OP_STORE;
					cmd.addr_a = cnt_q;
					term_nx    = '0;
					cnt_nx     = cnt_q + 4'd1;
					state_nx   = (cnt_q == 4'd15) ? ST_DLDA : ST_MINOR;
				end
			end
			ST_DLDA: begin
				// present the cofactor address while the pipe drains
				cmd.addr_a = {cnt_q[1:0], 2'd0};
				if (!sts.pipe_busy) begin
					state_nx = ST_DADJ;
				end
			end
			ST_DADJ: begin
				cmd.op     = OP_LDA_ADJ;
				cmd.addr_a = {cnt_q[1:0], 2'd0};
				state_nx   = ST_DET;
			end
			ST_DET: begin
				// row 0 expansion: adj(j,0) * a(0,j)
				cmd.op     = OP_MUL_AE;
				cmd.tgt    = TGT_D;
				cmd.chunk  = sub_q;
				cmd.addr_b = {2'd0, cnt_q[1:0]};
				cmd.first  = (cnt_q == 4'd0) && (sub_q == 2'd0);
				sub_nx     = sub_q + 2'd1;
				if (sub_q == 2'd2) begin
					sub_nx   = '0;
					cnt_nx   = cnt_q + 4'd1;
					state_nx = (cnt_q == 4'd3) ? ST_DWAIT : ST_DLDA;
				end
			end
			ST_DWAIT: begin
				if (!sts.pipe_busy) begin
					cmd.op   = OP_DLOAD;
					cnt_nx   = '0;
					state_nx = ST_CRD;
				end
			end
			ST_CRD: begin
				// present the cofactor address in the cycle before the load
				cmd.addr_a = cnt_q;
				state_nx   = ST_CLD;
			end
			ST_CLD: begin
				cmd.op     = OP_CLOAD;
				cmd.addr_a = cnt_q;
				state_nx   = ST_DCMP;
			end
			ST_DCMP: begin
				cmd.op   = OP_DCMP;
				div_nx   = '0;
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DSTEP;
				div_nx = div_q + 5'd1;
				if (div_q == 5'(DIV_STEPS - 1)) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.op   = OP_EMIT;
					cmd.last = (cnt_q == 4'd15);
					cnt_nx   = cnt_q + 4'd1;
					state_nx = (cnt_q == 4'd15) ? ST_IDLE : ST_CRD;
				end
			end
			ST_IDLE: begin
				cnt_nx   = '0;
				state_nx = ST_LOAD;
			end
			default: begin
				state_nx = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			term_q  <= '0;
			sub_q   <= '0;
			div_q   <= '0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= cnt_nx;
			term_q  <= term_nx;
			sub_q   <= sub_nx;
			div_q   <= div_nx;
		end
	end

endmodule

@@ hw/rtl/matrix4_inverse_adjugate.sv @@
// 4x4 matrix inverse by the adjugate, exact. Send sixteen signed Q16.16 elements in
// row-major order, one per in beat; after the sixteenth the block computes every
// cofactor and the determinant without rounding, then returns sixteen out beats in
// row-major order, each trunc(cofactor * 2^32 / det) clipped to 32 bits (saturated
// set when clipped), result_last on the sixteenth. A zero determinant gives the
// adjugate scaled down by 2^32 with singular set. All arithmetic runs through one
// shared 32x32 multiplier with a three-stage read/multiply/accumulate pipe and one
// restoring divider stepping one quotient bit a cycle. A matrix takes 16 load beats,
// then the cofactor and determinant steps (mostly pipe drain) and one division per
// result, an emit waiting while the output register is full and out_ready is low;
// in_ready stays low from the last load beat until the controller has passed through
// its idle state after the sixteenth result has been handed to the output register.
module matrix4_inverse_adjugate (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] elem_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic               result_last,
	output logic               singular,
	output logic               saturated
);
	import m4inv_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence the cofactor, determinant and division steps
	m4inv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold the matrix, the multiplier pipe, the divider and the output register
	m4inv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.elem_value   (elem_value),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.result_last  (result_last),
		.singular     (singular),
		.saturated    (saturated)
	);

endmodule
